FILE: hdl/gtsd_pkg.sv
// Package for the giant tour split block: field widths, register indexes,
// controller state type and the command/status structs between modules.
// No dependencies.
package gtsd_pkg;

  // Field widths fixed by the item formats
  localparam int DEMAND_W   = 16;
  localparam int DIST_W     = 20;
  localparam int CAP_W      = 24;
  localparam int PEN_W      = 16;
  localparam int COST_W     = 40;
  localparam int COUNT_W    = 9;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Default storage depth
  localparam int MAX_STOPS_DEF = 256;

  // Saturation ceiling of all costs
  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Register indexes (word address bit 2)
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_PENALTY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CAP_W-1:0] vehicle_capacity;
    logic [PEN_W-1:0] penalty_per_unit;
  } cfg_regs_t;

  typedef struct packed {
    logic load_item;  // word accepted: latch it and set up the walk
    logic walk_en;    // issue one back-walk read and step the index
    logic commit;     // finish the item and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic drop_in;    // word at the input would overrun storage
    logic walk_last;  // index at stop 1: this issue is the last one
    logic pipe_busy;  // candidates still in flight
  } dp_status_t;

endpackage

FILE: hdl/gtsd_in_if.sv
// Input channel of the giant tour split block: one stop per word.
// Depends on gtsd_pkg for field widths.
interface gtsd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           first_stop;
  logic [gtsd_pkg::DEMAND_W-1:0]  stop_demand;
  logic [gtsd_pkg::DIST_W-1:0]    dist_from_depot;
  logic [gtsd_pkg::DIST_W-1:0]    dist_to_depot;
  logic [gtsd_pkg::DIST_W-1:0]    dist_from_prev;

  modport source (
    output valid, first_stop, stop_demand, dist_from_depot, dist_to_depot,
           dist_from_prev,
    input  ready
  );

  modport sink (
    input  valid, first_stop, stop_demand, dist_from_depot, dist_to_depot,
           dist_from_prev,
    output ready
  );
endinterface

FILE: hdl/gtsd_out_if.sv
// Result channel of the giant tour split block: one word per stop.
// Depends on gtsd_pkg for field widths.
interface gtsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gtsd_pkg::COST_W-1:0]   best_prefix_cost;
  logic [gtsd_pkg::COUNT_W-1:0]  stop_count;
  logic                          overflow;

  modport source (
    output valid, best_prefix_cost, stop_count, overflow,
    input  ready
  );

  modport sink (
    input  valid, best_prefix_cost, stop_count, overflow,
    output ready
  );
endinterface

FILE: hdl/giant_tour_split_dp.sv
// Giant tour split block, top level: joins the configuration registers,
// the controller and the datapath. Depends on gtsd_pkg and both channel
// interfaces.
//
// Usage: stops of one giant tour arrive in order on in_chan, one per word;
// first_stop restarts the split. For every accepted stop one word leaves on
// out_chan with the least split cost of the prefix, the prefix length and a
// sticky overflow flag. vehicle_capacity (address 0) and penalty_per_unit
// (address 4) are written over the APB-style cfg_ port while idle.
// Stop j is walked back over all j earlier-or-equal stops, one memory
// read a cycle through a four-stage candidate pipeline; its word is
// committed once the pipeline has drained, and the next stop is taken
// only after that; a stop beyond MAX_STOPS is dropped and goes straight
// to commit, its word repeating the last stored cost.
// One item is in work at a time. The result sits in an output register, so
// the next stop is taken while it waits; a stalled receiver holds the block
// only when the following result is ready to commit.
// Reset (synchronous, rst_n low) clears the stop count, the overflow flag,
// the handshakes and both registers; no memory clearing pass is needed.
module giant_tour_split_dp #(
  parameter int MAX_STOPS = gtsd_pkg::MAX_STOPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gtsd_in_if.sink                         in_chan,
  gtsd_out_if.source                      out_chan,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gtsd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [gtsd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [gtsd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import gtsd_pkg::*;

  cfg_regs_t  cfg_regs;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  gtsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (cfg_regs)
  );

  gtsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gtsd_dp #(
    .MAX_STOPS (MAX_STOPS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_regs),
    .cmd              (cmd),
    .status           (status),
    .first_stop       (in_chan.first_stop),
    .stop_demand      (in_chan.stop_demand),
    .dist_from_depot  (in_chan.dist_from_depot),
    .dist_to_depot    (in_chan.dist_to_depot),
    .dist_from_prev   (in_chan.dist_from_prev),
    .best_prefix_cost (out_chan.best_prefix_cost),
    .stop_count       (out_chan.stop_count),
    .overflow         (out_chan.overflow)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

FILE: hdl/gtsd_cfg.sv
// APB-style configuration registers: vehicle capacity and penalty per unit.
// Depends on gtsd_pkg.
module gtsd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gtsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gtsd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gtsd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output gtsd_pkg::cfg_regs_t             regs
);
  import gtsd_pkg::*;

  cfg_regs_t regs_r, regs_nxt;
  logic      wr_en;
  logic      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // Write decode
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CAPACITY: regs_nxt.vehicle_capacity = pwdata[CAP_W-1:0];
        REG_PENALTY:  regs_nxt.penalty_per_unit = pwdata[PEN_W-1:0];
        default:      regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_idx)
      REG_CAPACITY: prdata = CFG_DATA_W'(regs_r.vehicle_capacity);
      REG_PENALTY:  prdata = CFG_DATA_W'(regs_r.penalty_per_unit);
      default:      prdata = '0;
    endcase
  end

  assign regs = regs_r;

endmodule

FILE: hdl/gtsd_ctrl.sv
// Controller state machine: accepts a stop, walks back, drains the pipe and
// commits the result; a dropped stop skips to commit. Depends on gtsd_pkg.
module gtsd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  gtsd_pkg::dp_status_t status,
  output gtsd_pkg::dp_cmd_t    cmd
);
  import gtsd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = ~out_valid_r | out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.drop_in ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.walk_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_WALK:   cmd.walk_en = 1'b1;
      ST_DRAIN:  cmd = '0;
      ST_FINISH: cmd.commit = out_free;
      default:   cmd = '0;
    endcase
  end

  // Result word valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/gtsd_dp.sv
// Datapath: prefix memories, back-walk index, candidate pipeline, running
// minimum and result register. Depends on gtsd_pkg.
module gtsd_dp #(
  parameter int MAX_STOPS = gtsd_pkg::MAX_STOPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gtsd_pkg::cfg_regs_t            cfg,
  input  gtsd_pkg::dp_cmd_t              cmd,
  output gtsd_pkg::dp_status_t           status,
  input  logic                           first_stop,
  input  logic [gtsd_pkg::DEMAND_W-1:0]  stop_demand,
  input  logic [gtsd_pkg::DIST_W-1:0]    dist_from_depot,
  input  logic [gtsd_pkg::DIST_W-1:0]    dist_to_depot,
  input  logic [gtsd_pkg::DIST_W-1:0]    dist_from_prev,
  output logic [gtsd_pkg::COST_W-1:0]    best_prefix_cost,
  output logic [gtsd_pkg::COUNT_W-1:0]   stop_count,
  output logic                           overflow
);
  import gtsd_pkg::*;

  localparam int AW     = $clog2(MAX_STOPS + 1);
  localparam int DEPTH  = MAX_STOPS + 1;
  localparam int LOAD_W = DEMAND_W + $clog2(MAX_STOPS);
  localparam int PATH_W = DIST_W + $clog2(MAX_STOPS);
  localparam int XW     = (LOAD_W > CAP_W) ? LOAD_W : CAP_W;
  localparam int PROD_W = PEN_W + LOAD_W;
  localparam int M1     = (PROD_W > COST_W) ? PROD_W : COST_W;
  localparam int M2     = (PATH_W > M1) ? PATH_W : M1;
  localparam int CAND_W = M2 + 3;

  // Prefix stores, indexed by stop number
  logic [COST_W-1:0] best_mem  [DEPTH];
  logic [LOAD_W-1:0] load_mem  [DEPTH];
  logic [PATH_W-1:0] path_mem  [DEPTH];
  logic [DIST_W-1:0] depot_mem [DEPTH];

  // Sequence state
  logic [AW-1:0]     stops_r;
  logic              seq_ovf_r;
  logic              drop_r;
  logic [AW-1:0]     j_r;
  logic [AW-1:0]     i_r;
  logic [LOAD_W-1:0] cur_load_r;
  logic [PATH_W-1:0] cur_path_r;
  logic [DIST_W-1:0] to_depot_r;
  logic [COST_W-1:0] last_best_r;
  logic [CAND_W-1:0] best_r;

  // Candidate pipeline
  logic              v1_r, v2_r, v3_r;
  logic              z1_r;
  logic [COST_W-1:0] bc_q;
  logic [LOAD_W-1:0] ld_q;
  logic [PATH_W-1:0] pd_q;
  logic [DIST_W-1:0] dd_q;
  logic [LOAD_W-1:0] exc_r;
  logic [CAND_W-1:0] base_r;
  logic [PROD_W-1:0] prod_r;
  logic [CAND_W-1:0] base2_r;

  // Result register
  logic [COST_W-1:0]  out_cost_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;

  logic [AW-1:0]     stops_eff;
  logic [AW-1:0]     j_new;
  logic [LOAD_W-1:0] load_new;
  logic [PATH_W-1:0] path_new;
  logic [AW-1:0]     addr_prev;
  logic [LOAD_W-1:0] ld_sel;
  logic [COST_W-1:0] bc_sel;
  logic [LOAD_W-1:0] load_diff;
  logic [XW-1:0]     diff_x;
  logic [XW-1:0]     cap_x;
  logic [LOAD_W-1:0] excess;
  logic [CAND_W-1:0] base;
  logic [CAND_W-1:0] cand;
  logic              sat;
  logic [COST_W-1:0] best_sat;
  logic              ovf_new;

  // Admission: restart on a first mark, drop when storage is full
  assign stops_eff = first_stop ? '0 : stops_r;
  assign j_new     = stops_eff + AW'(1);
  assign load_new  = (stops_eff == '0) ? LOAD_W'(stop_demand)
                                       : cur_load_r + LOAD_W'(stop_demand);
  assign path_new  = (stops_eff == '0) ? '0
                                       : cur_path_r + PATH_W'(dist_from_prev);

  assign status.drop_in   = ~first_stop & (stops_r >= AW'(MAX_STOPS));
  assign status.walk_last = (i_r == AW'(1));
  assign status.pipe_busy = v1_r | v2_r | v3_r;

  assign addr_prev = i_r - AW'(1);

  // Memories: written on admission or commit, read during the walk
  always_ff @(posedge clk) begin
    if (cmd.commit && !drop_r) best_mem[j_r] <= best_sat;
    if (cmd.walk_en) bc_q <= best_mem[addr_prev];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item && !status.drop_in) load_mem[j_new] <= load_new;
    if (cmd.walk_en) ld_q <= load_mem[addr_prev];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item && !status.drop_in) path_mem[j_new] <= path_new;
    if (cmd.walk_en) pd_q <= path_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item && !status.drop_in) depot_mem[j_new] <= dist_from_depot;
    if (cmd.walk_en) dd_q <= depot_mem[i_r];
  end

  // Control registers of the sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stops_r   <= '0;
      seq_ovf_r <= 1'b0;
      drop_r    <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
    end else begin
      v1_r <= cmd.walk_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.load_item) begin
        drop_r <= status.drop_in;
        if (first_stop) seq_ovf_r <= 1'b0;
        if (!status.drop_in) stops_r <= j_new;
      end else if (cmd.commit) begin
        seq_ovf_r <= drop_r ? 1'b1 : ovf_new;
      end
    end
  end

  // Item registers and back-walk index
  always_ff @(posedge clk) begin
    if (cmd.load_item && !status.drop_in) begin
      j_r        <= j_new;
      i_r        <= j_new;
      cur_load_r <= load_new;
      cur_path_r <= path_new;
      to_depot_r <= dist_to_depot;
    end else if (cmd.walk_en) begin
      i_r <= i_r - AW'(1);
    end
    z1_r <= (i_r == AW'(1));
  end

  // Stage 2: excess load and fixed part of the segment cost
  assign ld_sel    = z1_r ? '0 : ld_q;
  assign bc_sel    = z1_r ? '0 : bc_q;
  assign load_diff = cur_load_r - ld_sel;
  assign diff_x    = XW'(load_diff);
  assign cap_x     = XW'(cfg.vehicle_capacity);
  assign excess    = (diff_x > cap_x) ? LOAD_W'(diff_x - cap_x) : '0;
  assign base      = CAND_W'(bc_sel) + CAND_W'(dd_q)
                   + CAND_W'(cur_path_r - pd_q) + CAND_W'(to_depot_r);

  always_ff @(posedge clk) begin
    exc_r  <= excess;
    base_r <= base;
  end

  // Stage 3: capacity penalty
  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(cfg.penalty_per_unit) * PROD_W'(exc_r);
    base2_r <= base_r;
  end

  // Stage 4: candidate and running minimum
  assign cand = base2_r + CAND_W'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      best_r <= '1;
    end else if (v3_r && (cand < best_r)) begin
      best_r <= cand;
    end
  end

  // Saturation and commit
  assign sat      = best_r > CAND_W'(COST_MAX);
  assign best_sat = sat ? COST_MAX : best_r[COST_W-1:0];
  assign ovf_new  = seq_ovf_r | sat;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (drop_r) begin
        out_cost_r  <= last_best_r;
        out_count_r <= COUNT_W'(MAX_STOPS);
        out_ovf_r   <= 1'b1;
      end else begin
        out_cost_r  <= best_sat;
        out_count_r <= COUNT_W'(j_r);
        out_ovf_r   <= ovf_new;
        last_best_r <= best_sat;
      end
    end
  end

  assign best_prefix_cost = out_cost_r;
  assign stop_count       = out_count_r;
  assign overflow         = out_ovf_r;

endmodule

FILE: bench/giant_tour_split_dp_test.sv
`timescale 1ns / 100ps
// Self-checking bench for giant_tour_split_dp: a table of directed stops, a
// saturating overlong tour, then random tours under several register settings.
// Depends on gtsd_pkg, gtsd_in_if, gtsd_out_if and the block itself.
module giant_tour_split_dp_test;
  import gtsd_pkg::*;

  localparam int STOP_DEPTH = MAX_STOPS_DEF;

  typedef struct packed {
    logic                first_stop;
    logic [DEMAND_W-1:0] stop_demand;
    logic [DIST_W-1:0]   dist_from_depot;
    logic [DIST_W-1:0]   dist_to_depot;
    logic [DIST_W-1:0]   dist_from_prev;
  } stop_t;

  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } split_word_t;

  // one directed stop; want is used only where typed is set
  typedef struct packed {
    stop_t       stop;
    logic        typed;
    split_word_t want;
  } stop_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gtsd_in_if  in_chan ();
  gtsd_out_if out_chan ();

  giant_tour_split_dp u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Split state mirrored by the predictor
  logic [COST_W-1:0] best_cost_tab [0:STOP_DEPTH];
  logic [CAP_W-1:0]  load_tab      [0:STOP_DEPTH];
  logic [31:0]       path_tab      [0:STOP_DEPTH];
  logic [DIST_W-1:0] depot_tab     [1:STOP_DEPTH];
  int                stops_held;
  logic              tour_ovf;
  logic [CAP_W-1:0]  capacity_reg;
  logic [PEN_W-1:0]  penalty_reg;

  split_word_t split_q[$];
  int  errors, n_stops, n_words, n_tours, n_dropped, n_clamped, n_writes;
  bit  calm;

  // Directed stops, run under the reset register values (no penalty)
  stop_row_t dir_rows [15] = '{
    // no first mark after reset: taken as stop 1
    '{'{1'b0, 16'd5, 20'h00100, 20'h00200, 20'hFFFFF}, 1'b1, '{40'h300, 9'd1, 1'b0}},
    '{'{1'b0, 16'd7, 20'h00400, 20'h00080, 20'h00010}, 1'b0, '0},
    // all fields at their maximum
    '{'{1'b1, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b1,
      '{40'h1FFFFE, 9'd1, 1'b0}},
    '{'{1'b0, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b0, '0},
    '{'{1'b0, 16'h0000, 20'h00000, 20'h00000, 20'h00000}, 1'b0, '0},
    // all zero tour
    '{'{1'b1, 16'h0000, 20'h00000, 20'h00000, 20'h00000}, 1'b1, '{40'h0, 9'd1, 1'b0}},
    '{'{1'b0, 16'h0000, 20'h00000, 20'h00000, 20'h00000}, 1'b1, '{40'h0, 9'd2, 1'b0}},
    '{'{1'b1, 16'h0000, 20'hFFFFF, 20'h00000, 20'h00000}, 1'b1,
      '{40'hFFFFF, 9'd1, 1'b0}},
    '{'{1'b0, 16'hFFFF, 20'h00000, 20'hFFFFF, 20'h00000}, 1'b0, '0},
    '{'{1'b0, 16'h1234, 20'h12345, 20'h23456, 20'h0ABCD}, 1'b0, '0},
    '{'{1'b0, 16'hAAAA, 20'hAAAAA, 20'h55555, 20'hAAAAA}, 1'b0, '0},
    '{'{1'b0, 16'h5555, 20'h55555, 20'hAAAAA, 20'h55555}, 1'b0, '0},
    // first marks back to back
    '{'{1'b1, 16'd1, 20'h00100, 20'h00100, 20'h00000}, 1'b1, '{40'h200, 9'd1, 1'b0}},
    '{'{1'b1, 16'd0, 20'h00080, 20'h00080, 20'hFFFFF}, 1'b1, '{40'h100, 9'd1, 1'b0}},
    '{'{1'b0, 16'd0, 20'h00080, 20'h00080, 20'h00040}, 1'b0, '0}
  };

  // Best split cost of the tour so far, updating the mirrored state
  function automatic split_word_t split_stop(stop_t s);
    logic [63:0] best, cand, load, excess;
    int          i, j;
    if (s.first_stop) begin
      stops_held = 0;
      tour_ovf   = 1'b0;
    end
    // past storage: stop dropped, stored answer repeated
    if (stops_held >= STOP_DEPTH) begin
      tour_ovf = 1'b1;
      n_dropped++;
      return '{best_cost_tab[STOP_DEPTH], COUNT_W'(STOP_DEPTH), 1'b1};
    end
    j = stops_held + 1;
    if (j == 1) n_tours++;
    load_tab[j]  = load_tab[j-1] + s.stop_demand;
    path_tab[j]  = (j == 1) ? 32'd0 : path_tab[j-1] + s.dist_from_prev;
    depot_tab[j] = s.dist_from_depot;
    best = '1;
    // every route ending here, starting at stop i
    for (i = j; i >= 1; i--) begin
      load   = 64'(load_tab[j]) - 64'(load_tab[i-1]);
      excess = (load > 64'(capacity_reg)) ? load - 64'(capacity_reg) : 64'd0;
      cand   = 64'(best_cost_tab[i-1]) + 64'(depot_tab[i])
             + (64'(path_tab[j]) - 64'(path_tab[i])) + 64'(s.dist_to_depot)
             + 64'(penalty_reg) * excess;
      if (cand < best) best = cand;
    end
    if (best > 64'(COST_MAX)) begin
      best     = 64'(COST_MAX);
      tour_ovf = 1'b1;
      n_clamped++;
    end
    best_cost_tab[j] = best[COST_W-1:0];
    stops_held       = j;
    return '{best[COST_W-1:0], COUNT_W'(j), tour_ovf};
  endfunction

  // Present one stop, wait for it to be taken, log its expected word
  task automatic send_stop(input stop_t s, input logic typed = 1'b0,
                           input split_word_t want = '0);
    split_word_t w;
    while (!calm && $urandom_range(99) < 28) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.first_stop      <= s.first_stop;
    in_chan.stop_demand     <= s.stop_demand;
    in_chan.dist_from_depot <= s.dist_from_depot;
    in_chan.dist_to_depot   <= s.dist_to_depot;
    in_chan.dist_from_prev  <= s.dist_from_prev;
    do @(posedge clk); while (!in_chan.ready);
    w = split_stop(s);
    if (typed) w = want;
    split_q.insert(split_q.size(), w);
    n_stops++;
  endtask

  // Stop sending until every expected word is back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (split_q.size() != 0);
  endtask

  // APB write then read-back of one register; block must be idle
  task automatic cfg_write(input logic reg_idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] held, rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_idx == REG_CAPACITY) begin
      capacity_reg = value[CAP_W-1:0];
      held         = CFG_DATA_W'(capacity_reg);
    end else begin
      penalty_reg = value[PEN_W-1:0];
      held        = CFG_DATA_W'(penalty_reg);
    end
    n_writes++;
    if (rd !== held) begin
      errors++;
      $display("%0t: register %0d read back: expected %h, got %h", $time, reg_idx, held, rd);
    end
  endtask

  function automatic logic [DIST_W-1:0] pick_dist();
    case ($urandom_range(9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return DIST_W'($urandom_range(16'hFFFF));
      default:    return DIST_W'($urandom());
    endcase
  endfunction

  function automatic logic [DEMAND_W-1:0] pick_demand(int unsigned span);
    case ($urandom_range(9))
      0:             return '0;
      1:             return '1;
      2, 3, 4, 5, 6: return DEMAND_W'($urandom_range(span));
      default:       return DEMAND_W'($urandom());
    endcase
  endfunction

  // One tour of random stops; a loose tour may lack its first mark or
  // carry a stray one part way through
  task automatic send_tour(int len, int unsigned span, bit clean);
    stop_t s;
    int    k;
    for (k = 0; k < len; k++) begin
      if (clean) s.first_stop = (k == 0);
      else if (k == 0) s.first_stop = ($urandom_range(9) != 0);
      else s.first_stop = ($urandom_range(39) == 0);
      s.stop_demand     = pick_demand(span);
      s.dist_from_depot = pick_dist();
      s.dist_to_depot   = pick_dist();
      s.dist_from_prev  = pick_dist();
      send_stop(s);
    end
  endtask

  // New register setting, then random tours, mostly short
  task automatic run_phase(logic [CAP_W-1:0] cap, logic [PEN_W-1:0] pen, int quota,
                           int unsigned span, bit long_tour, bit hold_mid);
    int sent, len;
    bit held;
    drain_results();
    cfg_write(REG_CAPACITY, CFG_DATA_W'(cap));
    cfg_write(REG_PENALTY, CFG_DATA_W'(pen));
    sent = 0;
    held = 0;
    if (long_tour) begin
      len = STOP_DEPTH + $urandom_range(1, 6);
      send_tour(len, span, 1'b1);
      sent += len;
    end
    while (sent < quota) begin
      len = ($urandom_range(11) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      send_tour(len, span, ($urandom_range(3) != 0));
      sent += len;
      if (hold_mid && !held && sent >= quota / 2) begin
        drain_results();
        held = 1;
      end
    end
  endtask

  // Receiver: random back-pressure except in calm stretches
  initial out_chan.ready = 1'b0;
  always @(posedge clk) out_chan.ready <= calm || ($urandom_range(99) >= 28);

  // Result check against the oldest expectation
  always @(posedge clk) begin
    split_word_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_words++;
      if (split_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got cost %h count %0d ovf %b",
                 $time, out_chan.best_prefix_cost, out_chan.stop_count, out_chan.overflow);
      end else begin
        want = split_q.pop_front();
        if (out_chan.best_prefix_cost !== want.cost) begin
          errors++;
          $display("%0t: best_prefix_cost expected %h, got %h",
                   $time, want.cost, out_chan.best_prefix_cost);
        end
        if (out_chan.stop_count !== want.count) begin
          errors++;
          $display("%0t: stop_count expected %0d, got %0d",
                   $time, want.count, out_chan.stop_count);
        end
        if (out_chan.overflow !== want.ovf) begin
          errors++;
          $display("%0t: overflow expected %b, got %b", $time, want.ovf, out_chan.overflow);
        end
      end
    end
  end

  // Stimulus
  initial begin
    stop_t s;
    int    r, k;
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.first_stop      <= 1'b0;
    in_chan.stop_demand     <= '0;
    in_chan.dist_from_depot <= '0;
    in_chan.dist_to_depot   <= '0;
    in_chan.dist_from_prev  <= '0;
    cfg_psel                <= 1'b0;
    cfg_penable             <= 1'b0;
    cfg_pwrite              <= 1'b0;
    cfg_paddr               <= '0;
    cfg_pwdata              <= '0;
    calm             = 0;
    errors           = 0;
    n_stops          = 0;
    n_words          = 0;
    n_tours          = 0;
    n_dropped        = 0;
    n_clamped        = 0;
    n_writes         = 0;
    best_cost_tab[0] = '0;
    load_tab[0]      = '0;
    path_tab[0]      = '0;
    stops_held       = 0;
    tour_ovf         = 1'b0;
    capacity_reg     = '0;
    penalty_reg      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (r = 0; r < $size(dir_rows); r++)
      send_stop(dir_rows[r].stop, dir_rows[r].typed, dir_rows[r].want);

    // full storage of worst-case stops: cost saturates at the last stored
    // stop, further stops are dropped
    drain_results();
    cfg_write(REG_CAPACITY, '0);
    cfg_write(REG_PENALTY, CFG_DATA_W'(16'hFFFF));
    for (k = 0; k < STOP_DEPTH + 3; k++) begin
      s = '{(k == 0), 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
      send_stop(s);
    end

    // random tours under a spread of settings
    run_phase('0, 16'h0100, 125, 200, 1'b0, 1'b0);
    calm = 1;
    run_phase('1, 16'hFFFF, 125, 16'hFFFF, 1'b0, 1'b0);
    calm = 0;
    run_phase(24'd300, 16'h0040, 300, 200, 1'b1, 1'b0);
    run_phase(CAP_W'($urandom_range(2000)), PEN_W'($urandom()), 100, 300, 1'b0, 1'b1);
    run_phase(CAP_W'($urandom()), PEN_W'($urandom()), 100, 16'hFFFF, 1'b0, 1'b0);

    drain_results();
    repeat (20) @(posedge clk);
    $display("Run covered %0d stops in %0d tours over %0d register writes; %0d words checked.",
             n_stops, n_tours, n_writes, n_words);
    $display("Stops dropped past storage: %0d, costs clamped at saturation: %0d.",
             n_dropped, n_clamped);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
